// File: hw/rtl/clec_pkg.sv
package clec_pkg;

    localparam int CLEC_ADDR_BITS  = 48;
    localparam int CLEC_INDEX_BITS = 32;

    // output queue depth; must be a power of two and at least 2
    localparam int SEG_FIFO_DEPTH = 4;

    localparam int LINE_LOG2_MIN = 12;
    localparam int LINE_LOG2_MAX = 16;

    localparam logic CFG_LINE_SIZE_LOG2 = 1'b0;
    localparam logic CFG_DEVICE_BASE    = 1'b1;

    localparam logic [32:0] RUN_BYTES_MAX = '1;

    // one mapped line after address translation
    typedef struct packed {
        logic [48:0] laddr;
        logic [48:0] first_addr;
        logic [49:0] line_end;
        logic [16:0] line_bytes;
        logic [16:0] first_run;
        logic        first;
        logic        last;
        logic [31:0] req;
        logic [31:0] base;
        logic        dir;
        logic [15:0] end16;
    } t_line;

    // one merged segment
    typedef struct packed {
        logic [48:0] addr;
        logic [31:0] bytes;
        logic [32:0] buf_off;
        logic        dir;
        logic        last;
        logic        err;
    } t_seg;

endpackage

// File: hw/rtl/clec_line_map.sv
module clec_line_map
    import clec_pkg::*;
#(
    parameter int ADDR_BITS  = CLEC_ADDR_BITS,
    parameter int INDEX_BITS = CLEC_INDEX_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_line_index,
    input  logic        i_first_line,
    input  logic        i_last_line,
    input  logic [47:0] i_start_addr,
    input  logic [31:0] i_request_bytes,
    input  logic [31:0] i_buffer_base,
    input  logic        i_direction,
    input  logic        i_take,
    output logic        o_line_valid,
    output t_line       o_line
);

    localparam int          SA_BITS    = (ADDR_BITS < 48) ? ADDR_BITS : 48;
    localparam logic [47:0] START_MASK = 48'((49'(1) << SA_BITS) - 49'd1);
    localparam logic [31:0] INDEX_MASK = 32'((33'(1) << INDEX_BITS) - 33'd1);

    logic [4:0]  r_line_log2;
    logic [47:0] r_device_base;
    logic        r_valid;
    t_line       r_line;
    t_line       n_line;

    logic [4:0]  sh;
    logic [16:0] line_bytes;
    logic [15:0] lmask;
    logic [47:0] start_m;
    logic [15:0] seek;
    logic [47:0] idx_shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_log2   <= 5'(LINE_LOG2_MIN);
            r_device_base <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINE_SIZE_LOG2: r_line_log2   <= i_cfg_data[4:0];
                CFG_DEVICE_BASE:    r_device_base <= i_cfg_data;
                default:            r_device_base <= r_device_base;
            endcase
        end
    end

    always_comb begin
        priority if (r_line_log2 < 5'(LINE_LOG2_MIN)) begin
            sh = 5'(LINE_LOG2_MIN);
        end else if (r_line_log2 > 5'(LINE_LOG2_MAX)) begin
            sh = 5'(LINE_LOG2_MAX);
        end else begin
            sh = r_line_log2;
        end
    end

    assign line_bytes  = 17'd1 << sh;
    assign lmask       = 16'(line_bytes - 17'd1);
    assign start_m     = i_start_addr & START_MASK;
    assign seek        = start_m[15:0] & lmask;
    assign idx_shifted = 48'(i_line_index & INDEX_MASK) << sh;

    always_comb begin
        n_line.laddr      = 49'(r_device_base) + 49'(idx_shifted);
        n_line.first_addr = n_line.laddr + 49'(seek);
        n_line.line_end   = 50'(n_line.laddr) + 50'(line_bytes);
        n_line.line_bytes = line_bytes;
        n_line.first_run  = line_bytes - 17'(seek);
        n_line.first      = i_first_line;
        n_line.last       = i_last_line;
        n_line.req        = i_request_bytes;
        n_line.base       = i_buffer_base;
        n_line.dir        = i_direction;
        n_line.end16      = start_m[15:0] + i_request_bytes[15:0];
    end

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_line <= n_line;
        end
    end

    assign o_line_valid = r_valid;
    assign o_line       = r_line;

endmodule

// File: hw/rtl/clec_merge.sv
module clec_merge
    import clec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_line_valid,
    input  t_line       i_line,
    input  logic        i_room,
    output logic        o_take,
    output logic [1:0]  o_push_n,
    output t_seg        o_seg0,
    output t_seg        o_seg1
);

    logic [48:0] r_run_addr;
    logic [32:0] r_run_bytes;
    logic [49:0] r_run_end;
    logic [31:0] r_rem;
    logic [32:0] r_buf_off;
    logic        r_dir;
    logic [15:0] r_end16;

    logic [48:0] n_run_addr;
    logic [32:0] n_run_bytes;
    logic [49:0] n_run_end;
    logic [31:0] n_rem;
    logic [32:0] n_buf_off;

    logic        pending;
    logic        brk;
    logic        ext;
    logic [31:0] seg1;
    logic [31:0] rem_a;
    logic [32:0] off_a;
    logic [33:0] ext_sum;
    logic [32:0] run_bytes_a;
    logic        dir_a;
    logic [15:0] end16_a;
    logic [15:0] lmask;
    logic [15:0] tail;
    logic [16:0] skip_full;
    logic [15:0] skip;
    logic [32:0] run_t;
    logic [31:0] seg2;
    logic [31:0] rem_b;
    t_seg        seg_brk;
    t_seg        seg_fin;

    assign pending = r_run_bytes != '0;
    assign brk     = !i_line.first && pending && (50'(i_line.laddr) != r_run_end);
    assign ext     = !i_line.first && pending && !brk;

    // break segment, capped at the bytes still owed
    assign seg1 = (r_run_bytes < 33'(r_rem)) ? r_run_bytes[31:0] : r_rem;

    always_comb begin
        rem_a = r_rem;
        off_a = r_buf_off;
        if (i_line.first) begin
            rem_a = i_line.req;
            off_a = 33'(i_line.base);
        end else if (brk) begin
            rem_a = r_rem - seg1;
            off_a = r_buf_off + 33'(seg1);
        end
    end

    assign ext_sum = 34'(r_run_bytes) + 34'(i_line.line_bytes);

    always_comb begin
        if (i_line.first) begin
            n_run_addr  = i_line.first_addr;
            run_bytes_a = 33'(i_line.first_run);
            n_run_end   = i_line.line_end;
        end else if (ext) begin
            n_run_addr = r_run_addr;
            if (ext_sum[33]) begin
                run_bytes_a = RUN_BYTES_MAX;
                n_run_end   = 50'(r_run_addr) + 50'(RUN_BYTES_MAX);
            end else begin
                run_bytes_a = ext_sum[32:0];
                n_run_end   = r_run_end + 50'(i_line.line_bytes);
            end
        end else begin
            n_run_addr  = i_line.laddr;
            run_bytes_a = 33'(i_line.line_bytes);
            n_run_end   = i_line.line_end;
        end
    end

    assign dir_a   = i_line.first ? i_line.dir : r_dir;
    assign end16_a = i_line.first ? i_line.end16 : r_end16;

    // trim the unused tail of the last line
    assign lmask     = 16'(i_line.line_bytes - 17'd1);
    assign tail      = end16_a & lmask;
    assign skip_full = i_line.line_bytes - 17'(tail);
    assign skip      = skip_full[15:0] & lmask;
    assign run_t     = (run_bytes_a > 33'(skip)) ? run_bytes_a - 33'(skip) : '0;
    assign seg2      = (run_t < 33'(rem_a)) ? run_t[31:0] : rem_a;
    assign rem_b     = rem_a - seg2;

    always_comb begin
        seg_brk.addr    = r_run_addr;
        seg_brk.bytes   = seg1;
        seg_brk.buf_off = r_buf_off;
        seg_brk.dir     = r_dir;
        seg_brk.last    = 1'b0;
        seg_brk.err     = seg1 == '0;

        seg_fin.addr    = n_run_addr;
        seg_fin.bytes   = seg2;
        seg_fin.buf_off = off_a;
        seg_fin.dir     = dir_a;
        seg_fin.last    = 1'b1;
        seg_fin.err     = (seg2 == '0) || (rem_b != '0);
    end

    assign o_take   = i_line_valid && i_room;
    assign o_push_n = o_take ? (2'(brk) + 2'(i_line.last)) : 2'd0;
    assign o_seg0   = brk ? seg_brk : seg_fin;
    assign o_seg1   = seg_fin;

    assign n_run_bytes = i_line.last ? '0 : run_bytes_a;
    assign n_rem       = i_line.last ? rem_b : rem_a;
    assign n_buf_off   = i_line.last ? off_a + 33'(seg2) : off_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_addr  <= '0;
            r_run_bytes <= '0;
            r_run_end   <= '0;
            r_rem       <= '0;
            r_buf_off   <= '0;
            r_dir       <= 1'b0;
            r_end16     <= '0;
        end else if (o_take) begin
            r_run_addr  <= n_run_addr;
            r_run_bytes <= n_run_bytes;
            r_run_end   <= n_run_end;
            r_rem       <= n_rem;
            r_buf_off   <= n_buf_off;
            r_dir       <= dir_a;
            r_end16     <= end16_a;
        end
    end

endmodule

// File: hw/rtl/clec_seg_fifo.sv
module clec_seg_fifo
    import clec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_push_n,
    input  t_seg        i_seg0,
    input  t_seg        i_seg1,
    output logic        o_room,
    output logic        o_valid,
    input  logic        i_ready,
    output t_seg        o_seg
);

    localparam int PTR_W = $clog2(SEG_FIFO_DEPTH);
    localparam int CNT_W = $clog2(SEG_FIFO_DEPTH + 1);

    t_seg             r_mem [SEG_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] wr_next;
    logic             pop;

    assign wr_next = r_wr + PTR_W'(1);
    assign pop     = o_valid && i_ready;
    assign o_valid = r_count != '0;
    assign o_seg   = r_mem[r_rd];
    // room for the two segments a single line can produce
    assign o_room  = r_count <= CNT_W'(SEG_FIFO_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_seg0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_next] <= i_seg1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push_n);
            r_count <= r_count + CNT_W'(i_push_n) - CNT_W'(pop);
            if (pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/cache_line_extent_coalescer.sv
// Accepted lines are translated to device addresses, registered, then merged into the queue.
// Throughput: one line per cycle while the output queue has room; a line that closes a run
// and ends the request yields two segments, and the single output port then sets the pace at
// one segment per cycle.
// Reset (synchronous, active low) empties the pipeline and output queue, clears the open run
// and request totals, and sets the line size to 4 KiB and the device base to zero.
module cache_line_extent_coalescer
    import clec_pkg::*;
#(
    parameter int ADDR_BITS  = CLEC_ADDR_BITS,
    parameter int INDEX_BITS = CLEC_INDEX_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_line_index,
    input  logic        i_first_line,
    input  logic        i_last_line,
    input  logic [47:0] i_start_addr,
    input  logic [31:0] i_request_bytes,
    input  logic [31:0] i_buffer_base,
    input  logic        i_direction,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [48:0] o_seg_addr,
    output logic [31:0] o_seg_bytes,
    output logic [32:0] o_seg_buffer_offset,
    output logic        o_seg_direction,
    output logic        o_seg_last,
    output logic        o_seg_error
);

    logic       line_valid;
    t_line      line;
    logic       take;
    logic       room;
    logic [1:0] push_n;
    t_seg       seg0;
    t_seg       seg1;
    t_seg       seg_out;

    clec_line_map #(
        .ADDR_BITS  (ADDR_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_line_map (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_line_index    (i_line_index),
        .i_first_line    (i_first_line),
        .i_last_line     (i_last_line),
        .i_start_addr    (i_start_addr),
        .i_request_bytes (i_request_bytes),
        .i_buffer_base   (i_buffer_base),
        .i_direction     (i_direction),
        .i_take          (take),
        .o_line_valid    (line_valid),
        .o_line          (line)
    );

    clec_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_valid (line_valid),
        .i_line       (line),
        .i_room       (room),
        .o_take       (take),
        .o_push_n     (push_n),
        .o_seg0       (seg0),
        .o_seg1       (seg1)
    );

    clec_seg_fifo u_seg_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_seg0   (seg0),
        .i_seg1   (seg1),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_seg    (seg_out)
    );

    assign o_seg_addr          = seg_out.addr;
    assign o_seg_bytes         = seg_out.bytes;
    assign o_seg_buffer_offset = seg_out.buf_off;
    assign o_seg_direction     = seg_out.dir;
    assign o_seg_last          = seg_out.last;
    assign o_seg_error         = seg_out.err;

endmodule
